### rtl/core/rrts_pkg.sv
// Package for the round-robin task scheduler core.
// Holds sizes, request and status codes and the sequencer state type.
// No dependencies.
package rrts_pkg;

   localparam int MAX_TASKS    = 64;
   localparam int TASK_W       = $clog2(MAX_TASKS);
   localparam int KSTACK_BYTES = 4096;
   localparam int USTACK_BYTES = 4096;
   localparam logic [31:0] BASE_RESET = 32'h0020_0000;

   typedef enum logic [2:0] {
      REQ_CREATE   = 3'd0,
      REQ_DESTROY  = 3'd1,
      REQ_BLOCK    = 3'd2,
      REQ_UNBLOCK  = 3'd3,
      REQ_SET_CUR  = 3'd4,
      REQ_SCHEDULE = 3'd5
   } req_kind_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_NOT_LIVE = 2'd2,
      STAT_NO_RUN   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RM_START,
      ST_RM_LINK,
      ST_WALK,
      ST_SCHED,
      ST_DISPATCH_RD,
      ST_DISPATCH,
      ST_RESP
   } seq_state_type;

endpackage

### rtl/core/round_robin_task_scheduler_core.sv
// Round-robin task scheduler core: task table, FIFO ready queue, sequencer.
// Depends on rrts_pkg.
//
// Usage:
//   Request channel (req_valid/req_ready, req_type, req_task_id) takes one item
//   at a time; each item gives exactly one item on the response channel
//   (rsp_valid/rsp_ready, status, result id, running task, stack top).
//   csr_we/csr_wdata load the stack region base and restart region allocation;
//   write it only while no request is in flight.
// Sequencing, from acceptance to the response state:
//   destroy, block, set current: ST_RM_START, then ST_RM_LINK if the task is queued,
//     then ST_WALK over the queue entries (1 to MAX_TASKS-2) unless it is the head.
//   create: ST_SCAN, one task slot per step, for the lowest free id (1 to 63);
//     straight to the response when the stack space is exhausted.
//   schedule tick: ST_SCHED, ST_DISPATCH_RD, then ST_DISPATCH unless the queue is empty.
//   unblock, rejected and unknown requests: straight to the response.
//   The link memory walk and the slot scan take one step a cycle;
//   the next item is taken once the response is registered.
// Reset clears the live and queued bits, the queue, the current task and
//   restores the base to 0x200000. The link and stack memories are not cleared.
// A stalled receiver holds the response register; the core may accept and work
//   on the next item, then waits with its result until the register frees up.
module round_robin_task_scheduler_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [2:0]                   req_type,
   input  logic [rrts_pkg::TASK_W-1:0]  req_task_id,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic [rrts_pkg::TASK_W-1:0]  rsp_result_id,
   output logic [rrts_pkg::TASK_W-1:0]  rsp_running_id,
   output logic                         rsp_running_valid,
   output logic [31:0]                  rsp_stack_top,
   input  logic                         csr_we,
   input  logic [31:0]                  csr_wdata
);

   localparam int TW = rrts_pkg::TASK_W;
   localparam int NT = rrts_pkg::MAX_TASKS;
   localparam logic [33:0] REGION_BYTES =
      34'(rrts_pkg::KSTACK_BYTES + rrts_pkg::USTACK_BYTES);
   localparam logic [32:0] KSTACK_OFS = 33'(rrts_pkg::KSTACK_BYTES);
   localparam logic [33:0] ADDR_LIMIT = 34'h1_0000_0000;

   rrts_pkg::seq_state_type state_ff, state_in;

   logic [TW-1:0] id_ff, id_in, prev_ff, prev_in, link_id_ff, link_id_in;
   logic [TW-1:0] scan_ff, scan_in;
   logic [1:0]    status_ff, status_in;
   logic [TW-1:0] result_id_ff, result_id_in;
   logic [31:0]   stop_ff, stop_in;
   logic [NT-1:0] live_ff, live_in, queued_ff, queued_in;
   logic [TW-1:0] head_ff, head_in, tail_ff, tail_in, cur_ff, cur_in;
   logic          nonempty_ff, nonempty_in, cur_valid_ff, cur_valid_in;
   logic          running_ff, running_in;
   logic [32:0]   next_region_ff, next_region_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff;
   logic [TW-1:0] rsp_result_id_ff, rsp_running_id_ff;
   logic          rsp_running_valid_ff;
   logic [31:0]   rsp_stack_top_ff;
   logic          rsp_load;

   // link and stack memories
   logic [TW-1:0] link_mem [NT];
   logic [31:0]   kstack_mem [NT];
   logic [TW-1:0] rd_addr, link_q;
   logic [31:0]   kstack_q;
   logic          link_we, kstack_we;
   logic [TW-1:0] link_waddr, link_wdata;
   logic [31:0]   kstack_wdata;

   logic          append_en;
   logic [TW-1:0] append_id;
   logic          accept, id_ok, rsp_free, is_cur;
   logic [33:0]   region_end;
   logic [2:0]    req_kind;

   assign accept     = req_valid && req_ready;
   assign req_ready  = (state_ff == rrts_pkg::ST_IDLE);
   assign id_ok      = (req_task_id != '0) && live_ff[req_task_id];
   assign is_cur     = cur_valid_ff && (cur_ff == req_task_id);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign region_end = {1'b0, next_region_ff} + REGION_BYTES;
   assign req_kind   = req_type;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rrts_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_kind)
                  rrts_pkg::REQ_CREATE:
                     state_in = (region_end > ADDR_LIMIT) ? rrts_pkg::ST_RESP
                                                          : rrts_pkg::ST_SCAN;
                  rrts_pkg::REQ_DESTROY, rrts_pkg::REQ_BLOCK, rrts_pkg::REQ_SET_CUR:
                     state_in = id_ok ? rrts_pkg::ST_RM_START : rrts_pkg::ST_RESP;
                  rrts_pkg::REQ_SCHEDULE: state_in = rrts_pkg::ST_SCHED;
                  default: state_in = rrts_pkg::ST_RESP;
               endcase
            end
         end
         rrts_pkg::ST_SCAN: begin
            if (!live_ff[scan_ff] || scan_ff == TW'(NT - 1))
               state_in = rrts_pkg::ST_RESP;
         end
         rrts_pkg::ST_RM_START: begin
            state_in = (queued_ff[id_ff] && nonempty_ff) ? rrts_pkg::ST_RM_LINK
                                                          : rrts_pkg::ST_RESP;
         end
         rrts_pkg::ST_RM_LINK: begin
            state_in = (head_ff == id_ff) ? rrts_pkg::ST_RESP : rrts_pkg::ST_WALK;
         end
         rrts_pkg::ST_WALK: begin
            if (prev_ff == tail_ff || link_q == id_ff)
               state_in = rrts_pkg::ST_RESP;
         end
         rrts_pkg::ST_SCHED: state_in = rrts_pkg::ST_DISPATCH_RD;
         rrts_pkg::ST_DISPATCH_RD: begin
            state_in = nonempty_ff ? rrts_pkg::ST_DISPATCH : rrts_pkg::ST_RESP;
         end
         rrts_pkg::ST_DISPATCH: state_in = rrts_pkg::ST_RESP;
         rrts_pkg::ST_RESP: begin
            if (rsp_free)
               state_in = rrts_pkg::ST_IDLE;
         end
         default: state_in = rrts_pkg::ST_IDLE;
      endcase
   end

   // datapath and table updates
   always_comb begin
      id_in          = id_ff;
      prev_in        = prev_ff;
      link_id_in     = link_id_ff;
      scan_in        = scan_ff;
      status_in      = status_ff;
      result_id_in   = result_id_ff;
      stop_in        = stop_ff;
      live_in        = live_ff;
      queued_in      = queued_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      nonempty_in    = nonempty_ff;
      cur_in         = cur_ff;
      cur_valid_in   = cur_valid_ff;
      running_in     = running_ff;
      next_region_in = next_region_ff;
      rd_addr        = id_ff;
      link_we        = 1'b0;
      link_waddr     = tail_ff;
      link_wdata     = '0;
      kstack_we      = 1'b0;
      kstack_wdata   = '0;
      append_en      = 1'b0;
      append_id      = id_ff;
      rsp_load       = 1'b0;

      case (state_ff)
         rrts_pkg::ST_IDLE: begin
            if (accept) begin
               id_in        = req_task_id;
               status_in    = rrts_pkg::STAT_OK;
               result_id_in = '0;
               stop_in      = '0;
               scan_in      = TW'(1);
               case (req_kind)
                  rrts_pkg::REQ_CREATE: begin
                     if (region_end > ADDR_LIMIT)
                        status_in = rrts_pkg::STAT_FULL;
                  end
                  rrts_pkg::REQ_DESTROY: begin
                     if (!id_ok) begin
                        status_in = rrts_pkg::STAT_NOT_LIVE;
                     end else begin
                        live_in[req_task_id] = 1'b0;
                        if (is_cur) begin
                           cur_valid_in = 1'b0;
                           running_in   = 1'b0;
                        end
                     end
                  end
                  rrts_pkg::REQ_BLOCK: begin
                     if (!id_ok)
                        status_in = rrts_pkg::STAT_NOT_LIVE;
                     else if (is_cur)
                        running_in = 1'b0;
                  end
                  rrts_pkg::REQ_UNBLOCK: begin
                     if (!id_ok) begin
                        status_in = rrts_pkg::STAT_NOT_LIVE;
                     end else if (!queued_ff[req_task_id]) begin
                        append_en = 1'b1;
                        append_id = req_task_id;
                        if (is_cur)
                           running_in = 1'b0;
                     end
                  end
                  rrts_pkg::REQ_SET_CUR: begin
                     if (!id_ok) begin
                        status_in = rrts_pkg::STAT_NOT_LIVE;
                     end else begin
                        cur_in       = req_task_id;
                        cur_valid_in = 1'b1;
                        running_in   = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // one slot per cycle, lowest free id first
         rrts_pkg::ST_SCAN: begin
            rd_addr = scan_ff;
            if (!live_ff[scan_ff]) begin
               live_in[scan_ff] = 1'b1;
               kstack_we        = 1'b1;
               kstack_wdata     = 32'(next_region_ff + KSTACK_OFS);
               next_region_in   = region_end[32:0];
               append_en        = 1'b1;
               append_id        = scan_ff;
               result_id_in     = scan_ff;
               stop_in          = 32'(next_region_ff + KSTACK_OFS);
            end else if (scan_ff == TW'(NT - 1)) begin
               status_in = rrts_pkg::STAT_FULL;
            end else begin
               scan_in = scan_ff + TW'(1);
            end
         end
         // fetch the link of the task to unlink
         rrts_pkg::ST_RM_START: begin
            rd_addr = id_ff;
         end
         rrts_pkg::ST_RM_LINK: begin
            link_id_in = link_q;
            if (head_ff == id_ff) begin
               if (tail_ff == id_ff)
                  nonempty_in = 1'b0;
               else
                  head_in = link_q;
               queued_in[id_ff] = 1'b0;
            end else begin
               rd_addr = head_ff;
               prev_in = head_ff;
            end
         end
         // follow links until the predecessor is found
         rrts_pkg::ST_WALK: begin
            if (prev_ff == tail_ff) begin
               queued_in[id_ff] = 1'b0;
            end else if (link_q == id_ff) begin
               link_we    = 1'b1;
               link_waddr = prev_ff;
               link_wdata = link_id_ff;
               if (tail_ff == id_ff)
                  tail_in = prev_ff;
               queued_in[id_ff] = 1'b0;
            end else begin
               prev_in = link_q;
               rd_addr = link_q;
            end
         end
         // requeue a running current task at the tail
         rrts_pkg::ST_SCHED: begin
            if (running_ff) begin
               append_en  = 1'b1;
               append_id  = cur_ff;
               running_in = 1'b0;
            end
         end
         rrts_pkg::ST_DISPATCH_RD: begin
            rd_addr = head_ff;
            if (!nonempty_ff)
               status_in = rrts_pkg::STAT_NO_RUN;
         end
         // pop the head and make it run
         rrts_pkg::ST_DISPATCH: begin
            if (tail_ff == head_ff)
               nonempty_in = 1'b0;
            else
               head_in = link_q;
            queued_in[head_ff] = 1'b0;
            cur_in       = head_ff;
            cur_valid_in = 1'b1;
            running_in   = 1'b1;
            result_id_in = head_ff;
            stop_in      = kstack_q;
         end
         rrts_pkg::ST_RESP: begin
            rsp_load = rsp_free;
         end
         default: ;
      endcase

      // append to the ready queue tail
      if (append_en) begin
         if (nonempty_ff) begin
            link_we    = 1'b1;
            link_waddr = tail_ff;
            link_wdata = append_id;
         end else begin
            head_in = append_id;
         end
         tail_in              = append_id;
         nonempty_in          = 1'b1;
         queued_in[append_id] = 1'b1;
      end

      // base write restarts allocation
      if (csr_we)
         next_region_in = {1'b0, csr_wdata};
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= rrts_pkg::ST_IDLE;
         live_ff        <= '0;
         queued_ff      <= '0;
         head_ff        <= '0;
         tail_ff        <= '0;
         nonempty_ff    <= 1'b0;
         cur_ff         <= '0;
         cur_valid_ff   <= 1'b0;
         running_ff     <= 1'b0;
         next_region_ff <= {1'b0, rrts_pkg::BASE_RESET};
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         live_ff        <= live_in;
         queued_ff      <= queued_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         nonempty_ff    <= nonempty_in;
         cur_ff         <= cur_in;
         cur_valid_ff   <= cur_valid_in;
         running_ff     <= running_in;
         next_region_ff <= next_region_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // work and response payload
   always_ff @(posedge clock) begin
      id_ff        <= id_in;
      prev_ff      <= prev_in;
      link_id_ff   <= link_id_in;
      scan_ff      <= scan_in;
      status_ff    <= status_in;
      result_id_ff <= result_id_in;
      stop_ff      <= stop_in;
      if (rsp_load) begin
         rsp_status_ff        <= status_ff;
         rsp_result_id_ff     <= result_id_ff;
         rsp_running_id_ff    <= running_ff ? cur_ff : '0;
         rsp_running_valid_ff <= running_ff;
         rsp_stack_top_ff     <= stop_ff;
      end
   end

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (link_we)
         link_mem[link_waddr] <= link_wdata;
      link_q <= link_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (kstack_we)
         kstack_mem[scan_ff] <= kstack_wdata;
      kstack_q <= kstack_mem[rd_addr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_id     = rsp_result_id_ff;
   assign rsp_running_id    = rsp_running_id_ff;
   assign rsp_running_valid = rsp_running_valid_ff;
   assign rsp_stack_top     = rsp_stack_top_ff;

endmodule

### rtl/core/rrts_checker.sv
// Port-level checks for the round-robin task scheduler core.
// Depends on rrts_pkg; bound to round_robin_task_scheduler_core.
module rrts_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [1:0]                   rsp_status,
   input logic [rrts_pkg::TASK_W-1:0]  rsp_result_id,
   input logic [rrts_pkg::TASK_W-1:0]  rsp_running_id,
   input logic                         rsp_running_valid,
   input logic [31:0]                  rsp_stack_top
);

   // hold a stalled item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_result_id) && $stable(rsp_stack_top))
      else $error("response changed while stalled");

   // failed requests give no id and no stack
   a_fail_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != rrts_pkg::STAT_OK |->
         rsp_result_id == '0 && rsp_stack_top == '0)
      else $error("failed request returned id or stack");

   // idle core reports running id zero
   a_run_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_running_valid |-> rsp_running_id == '0)
      else $error("running id without running task");

   // nothing runnable means nothing runs
   a_no_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == rrts_pkg::STAT_NO_RUN |-> !rsp_running_valid)
      else $error("task running while queue empty");

endmodule

bind round_robin_task_scheduler_core rrts_checker u_rrts_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_result_id     (rsp_result_id),
   .rsp_running_id    (rsp_running_id),
   .rsp_running_valid (rsp_running_valid),
   .rsp_stack_top     (rsp_stack_top)
);

### tb/tb_top.sv
// Self-checking testbench for round_robin_task_scheduler_core.
// Depends on rrts_pkg and the core. A task table predictor or a directed row checks every response.
module tb_top;

   typedef struct packed {
      logic [1:0]                  status;
      logic [rrts_pkg::TASK_W-1:0] result_id;
      logic [rrts_pkg::TASK_W-1:0] running_id;
      logic                        running_valid;
      logic [31:0]                 stack_top;
   } sched_rsp_type;

   typedef struct {
      bit            is_csr;
      logic [2:0]    kind;
      int            tid;
      logic [31:0]   wdata;
      bit            typed;
      sched_rsp_type want;
   } stim_row_type;

   localparam logic [1:0] MODE_READY   = 2'd0;
   localparam logic [1:0] MODE_RUNNING = 2'd1;
   localparam logic [1:0] MODE_BLOCKED = 2'd2;
   localparam int DRAIN_CYCLES = 2 * rrts_pkg::MAX_TASKS + 20;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_type = '0;
   logic [rrts_pkg::TASK_W-1:0] req_task_id = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [rrts_pkg::TASK_W-1:0] rsp_result_id;
   logic [rrts_pkg::TASK_W-1:0] rsp_running_id;
   logic rsp_running_valid;
   logic [31:0] rsp_stack_top;
   logic csr_we = 1'b0;
   logic [31:0] csr_wdata = '0;

   round_robin_task_scheduler_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_type(req_type), .req_task_id(req_task_id),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_result_id(rsp_result_id),
      .rsp_running_id(rsp_running_id), .rsp_running_valid(rsp_running_valid),
      .rsp_stack_top(rsp_stack_top),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // Mirror of the task table
   bit          t_live   [rrts_pkg::MAX_TASKS];
   bit          t_queued [rrts_pkg::MAX_TASKS];
   logic [1:0]  t_mode   [rrts_pkg::MAX_TASKS];
   int          t_link   [rrts_pkg::MAX_TASKS];
   logic [31:0] t_kstack [rrts_pkg::MAX_TASKS];
   int          q_head, q_tail;
   bit          q_any;
   int          cur_id;
   bit          cur_ok;
   longint unsigned region_next;

   sched_rsp_type pending_rsp[$];
   int            fail_count = 0;

   function automatic void table_clear(logic [31:0] base);
      for (int i = 0; i < rrts_pkg::MAX_TASKS; i++) begin
         t_live[i] = 0;
         t_queued[i] = 0;
         t_mode[i] = MODE_READY;
         t_link[i] = 0;
         t_kstack[i] = '0;
      end
      q_head = 0;
      q_tail = 0;
      q_any = 0;
      cur_id = 0;
      cur_ok = 0;
      region_next = base;
   endfunction

   function automatic void ready_push(int id);
      if (q_any) t_link[q_tail] = id;
      else q_head = id;
      q_tail = id;
      t_link[id] = 0;
      q_any = 1;
      t_queued[id] = 1;
   endfunction

   function automatic void ready_pull(int id);
      int prev;
      if (!t_queued[id] || !q_any) return;
      if (q_head == id) begin
         if (q_tail == id) q_any = 0;
         else q_head = t_link[id];
      end else begin
         prev = q_head;
         for (int s = 0; s < rrts_pkg::MAX_TASKS; s++) begin
            if (t_link[prev] == id || prev == q_tail) break;
            prev = t_link[prev];
         end
         if (t_link[prev] == id && prev != q_tail) begin
            t_link[prev] = t_link[id];
            if (q_tail == id) q_tail = prev;
         end
      end
      t_queued[id] = 0;
   endfunction

   // Advance the table by one request and return the response it gives
   function automatic sched_rsp_type sched_step(logic [2:0] kind, int tid);
      sched_rsp_type r;
      int id;
      bit alive;
      longint unsigned top_end;
      r = '0;
      alive = tid != 0 && tid < rrts_pkg::MAX_TASKS && t_live[tid];
      case (kind)
         rrts_pkg::REQ_CREATE: begin
            top_end = region_next + rrts_pkg::KSTACK_BYTES + rrts_pkg::USTACK_BYTES;
            id = 0;
            for (int i = 1; i < rrts_pkg::MAX_TASKS; i++)
               if (!t_live[i]) begin
                  id = i;
                  break;
               end
            if (id == 0 || top_end > 64'h1_0000_0000) r.status = rrts_pkg::STAT_FULL;
            else begin
               t_live[id] = 1;
               t_mode[id] = MODE_READY;
               t_kstack[id] = 32'(region_next + rrts_pkg::KSTACK_BYTES);
               region_next = top_end;
               ready_push(id);
               r.result_id = id[rrts_pkg::TASK_W-1:0];
               r.stack_top = t_kstack[id];
            end
         end
         rrts_pkg::REQ_DESTROY: begin
            if (!alive) r.status = rrts_pkg::STAT_NOT_LIVE;
            else begin
               ready_pull(tid);
               t_live[tid] = 0;
               if (cur_ok && cur_id == tid) cur_ok = 0;
            end
         end
         rrts_pkg::REQ_BLOCK: begin
            if (!alive) r.status = rrts_pkg::STAT_NOT_LIVE;
            else begin
               t_mode[tid] = MODE_BLOCKED;
               ready_pull(tid);
            end
         end
         rrts_pkg::REQ_UNBLOCK: begin
            if (!alive) r.status = rrts_pkg::STAT_NOT_LIVE;
            else if (!t_queued[tid]) begin
               t_mode[tid] = MODE_READY;
               ready_push(tid);
            end
         end
         rrts_pkg::REQ_SET_CUR: begin
            if (!alive) r.status = rrts_pkg::STAT_NOT_LIVE;
            else begin
               cur_id = tid;
               cur_ok = 1;
               t_mode[tid] = MODE_RUNNING;
               ready_pull(tid);
            end
         end
         rrts_pkg::REQ_SCHEDULE: begin
            if (cur_ok && t_mode[cur_id] == MODE_RUNNING) begin
               t_mode[cur_id] = MODE_READY;
               ready_pull(cur_id);
               ready_push(cur_id);
            end
            if (!q_any) r.status = rrts_pkg::STAT_NO_RUN;
            else begin
               id = q_head;
               ready_pull(id);
               t_mode[id] = MODE_RUNNING;
               cur_id = id;
               cur_ok = 1;
               r.result_id = id[rrts_pkg::TASK_W-1:0];
               r.stack_top = t_kstack[id];
            end
         end
         default: ;
      endcase
      if (cur_ok && t_mode[cur_id] == MODE_RUNNING) begin
         r.running_id = cur_id[rrts_pkg::TASK_W-1:0];
         r.running_valid = 1'b1;
      end
      return r;
   endfunction

   // Offer one item and hold it until accepted, then record the expectation
   task automatic send_item(logic [2:0] kind, int tid, bit typed, sched_rsp_type want);
      sched_rsp_type got;
      req_type <= kind;
      req_task_id <= tid[rrts_pkg::TASK_W-1:0];
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      got = sched_step(kind, tid);
      pending_rsp.push_back(typed ? want : got);
   endtask

   // Wait for the core to drain, then load the base register
   task automatic write_base(logic [31:0] base);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= base;
      @(posedge clock);
      csr_we <= 1'b0;
      region_next = base;
   endtask

   // Pick a task id, mostly a live one
   function automatic int pick_id();
      int live_ids[$];
      for (int i = 1; i < rrts_pkg::MAX_TASKS; i++) if (t_live[i]) live_ids.push_back(i);
      if (live_ids.size() != 0 && $urandom_range(0, 9) < 7)
         return live_ids[$urandom_range(0, live_ids.size() - 1)];
      return $urandom_range(0, rrts_pkg::MAX_TASKS - 1);
   endfunction

   // Receiver stall pattern: a new mode is drawn when the low six bits of stall_cnt are zero
   int unsigned stall_mode = 0;
   int unsigned stall_cnt = 0;
   always @(posedge clock) begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt[5:0] == 6'd0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= stall_cnt[1];
         default: rsp_ready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   // Compare each accepted response with the oldest expectation
   always @(posedge clock) begin
      sched_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("response with nothing expected");
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_result_id !== want.result_id) begin
               $error("result_id: expected %0d, got %0d", want.result_id, rsp_result_id);
               fail_count++;
            end
            if (rsp_running_id !== want.running_id) begin
               $error("running_id: expected %0d, got %0d",
                      want.running_id, rsp_running_id);
               fail_count++;
            end
            if (rsp_running_valid !== want.running_valid) begin
               $error("running_valid: expected %0d, got %0d",
                      want.running_valid, rsp_running_valid);
               fail_count++;
            end
            if (rsp_stack_top !== want.stack_top) begin
               $error("stack_top: expected %h, got %h", want.stack_top, rsp_stack_top);
               fail_count++;
            end
         end
      end
   end

   function automatic stim_row_type row_req(logic [2:0] kind, int tid);
      stim_row_type s;
      s = '{default: '0};
      s.kind = kind;
      s.tid = tid;
      return s;
   endfunction

   function automatic stim_row_type row_chk(logic [2:0] kind, int tid, logic [1:0] st,
                                            int rid, int run, logic [31:0] top);
      stim_row_type s;
      s = row_req(kind, tid);
      s.typed = 1;
      s.want = '{st, rid[rrts_pkg::TASK_W-1:0], run[rrts_pkg::TASK_W-1:0],
                 run != 0, top};
      return s;
   endfunction

   function automatic stim_row_type row_csr(logic [31:0] base);
      stim_row_type s;
      s = '{default: '0};
      s.is_csr = 1;
      s.wdata = base;
      return s;
   endfunction

   stim_row_type directed[$];
   logic [31:0] phase_base[6] = '{32'h0000_0000, 32'h0020_0000, 32'hFFFF_0000,
                                  32'h8000_0000, 32'hFFFF_FFFF, 32'h1234_5000};

   initial begin
      int gap, burst, roll;
      logic [2:0] kind;
      table_clear(rrts_pkg::BASE_RESET);
      directed = '{
         row_chk(rrts_pkg::REQ_SCHEDULE, 0, rrts_pkg::STAT_NO_RUN, 0, 0, 0),
         row_chk(rrts_pkg::REQ_DESTROY, 0, rrts_pkg::STAT_NOT_LIVE, 0, 0, 0),
         row_chk(rrts_pkg::REQ_BLOCK, 63, rrts_pkg::STAT_NOT_LIVE, 0, 0, 0),
         row_chk(rrts_pkg::REQ_CREATE, 0, rrts_pkg::STAT_OK, 1, 0, 32'h0020_1000),
         row_chk(rrts_pkg::REQ_CREATE, 63, rrts_pkg::STAT_OK, 2, 0, 32'h0020_3000),
         row_req(rrts_pkg::REQ_CREATE, 0),
         row_req(rrts_pkg::REQ_UNBLOCK, 1),
         row_req(rrts_pkg::REQ_SET_CUR, 2),
         row_req(rrts_pkg::REQ_SCHEDULE, 0),
         row_req(rrts_pkg::REQ_BLOCK, 1),
         row_req(rrts_pkg::REQ_SCHEDULE, 0),
         row_req(rrts_pkg::REQ_BLOCK, 3),
         row_req(rrts_pkg::REQ_UNBLOCK, 1),
         row_req(rrts_pkg::REQ_DESTROY, 2),
         row_chk(3'd6, 5, rrts_pkg::STAT_OK, 0, 0, 0),
         row_chk(3'd7, 42, rrts_pkg::STAT_OK, 0, 0, 0),
         row_req(rrts_pkg::REQ_SCHEDULE, 0),
         row_chk(rrts_pkg::REQ_UNBLOCK, 2, rrts_pkg::STAT_NOT_LIVE, 0, 1, 0),
         row_csr(32'hFFFF_FFFF),
         row_req(rrts_pkg::REQ_CREATE, 0),
         row_csr(32'hFFFF_E000),
         row_req(rrts_pkg::REQ_CREATE, 0),
         row_req(rrts_pkg::REQ_CREATE, 0),
         row_req(rrts_pkg::REQ_SCHEDULE, 0)
      };
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      foreach (directed[i]) begin
         if (directed[i].is_csr) write_base(directed[i].wdata);
         else send_item(directed[i].kind, directed[i].tid, directed[i].typed,
                        directed[i].want);
      end

      // Random phases, each with its own base; phase 0 draws more creates than the others
      for (int p = 0; p < 6; p++) begin
         write_base(phase_base[p]);
         burst = 0;
         for (int n = 0; n < 250; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < (p == 0 ? 45 : 22)) kind = rrts_pkg::REQ_CREATE;
            else if (roll < 60) kind = rrts_pkg::REQ_SCHEDULE;
            else if (roll < 70) kind = rrts_pkg::REQ_BLOCK;
            else if (roll < 80) kind = rrts_pkg::REQ_UNBLOCK;
            else if (roll < 88) kind = rrts_pkg::REQ_SET_CUR;
            else if (roll < 97) kind = rrts_pkg::REQ_DESTROY;
            else kind = 3'($urandom_range(6, 7));
            send_item(kind, pick_id(), 0, '0);
            if (burst == 0) begin
               burst = $urandom_range(1, 20);
               gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
               if (gap != 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end else burst--;
         end
      end

      // Drain
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   // Timeout
   initial begin
      #40000000;
      $display("FAIL");
      $finish;
   end

endmodule
